// ===== rtl/core/psnm_pkg.sv =====
// Shared types and constants for the palette shade nearest-match block.
// Holds the transaction payload structs, register indexes and the internal
// palette command and candidate tag structs. No dependencies.
`timescale 1ns / 1ps

package psnm_pkg;

   // Field widths
   localparam int CHAN_W      = 6;
   localparam int COLOR_W     = 3 * CHAN_W;
   localparam int ENTRY_W     = 8;
   localparam int INTENSITY_W = 9;
   localparam int DIST_W      = 12;
   localparam int SUM_W       = 14;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   // Sizing and reset values
   localparam int ENTRIES_DEFAULT = 256;
   localparam logic [DIST_W-1:0]      DIST_LIMIT      = 12'd4095;
   localparam logic [INTENSITY_W-1:0] INTENSITY_RESET = 9'd160;
   localparam logic [INTENSITY_W-1:0] INTENSITY_FULL  = 9'd256;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_INTENSITY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RED   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_GREEN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BLUE  = 2'd3;

   // Request actions
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ENTRY_W-1:0] entry;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic              usable;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] queried_entry;
      logic [ENTRY_W-1:0] match_entry;
      logic [DIST_W-1:0]  best_distance;
   } rsp_type;

   // Palette access: one write port, one read port
   typedef struct packed {
      logic               wr_en;
      logic [ENTRY_W-1:0] wr_addr;
      logic               wr_avail;
      logic [COLOR_W-1:0] wr_color;
      logic [ENTRY_W-1:0] rd_addr;
   } pal_cmd_type;

   // Tag that travels with a scan candidate
   typedef struct packed {
      logic               valid;
      logic               avail;
      logic [ENTRY_W-1:0] idx;
   } cand_type;

endpackage

// ===== rtl/core/psnm_palette.sv =====
// Palette store: colour and availability memory with one write and one
// registered read port, plus per-entry written flags cleared at reset.
// Depends on psnm_pkg.
`timescale 1ns / 1ps

module psnm_palette #(
   parameter int ENTRIES = psnm_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psnm_pkg::pal_cmd_type         cmd,
   output logic [psnm_pkg::COLOR_W-1:0]  rd_color,
   output logic                          rd_avail
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WORD_W = psnm_pkg::COLOR_W + 1;

   logic [WORD_W-1:0]  mem [ENTRIES];
   logic [ENTRIES-1:0] written_ff;
   logic [ENTRIES-1:0] written_in;
   logic [WORD_W-1:0]  rd_word_ff;
   logic               rd_written_ff;

   // Mark an entry once it has been loaded
   always_comb begin
      written_in = written_ff;
      if (cmd.wr_en) begin
         written_in[cmd.wr_addr[IDX_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[IDX_W-1:0]] <= {cmd.wr_avail, cmd.wr_color};
      end
      rd_word_ff    <= mem[cmd.rd_addr[IDX_W-1:0]];
      rd_written_ff <= written_ff[cmd.rd_addr[IDX_W-1:0]];
   end

   // An entry never loaded reads as black and available
   assign rd_color = rd_written_ff ? rd_word_ff[psnm_pkg::COLOR_W-1:0] : '0;
   assign rd_avail = rd_written_ff ? rd_word_ff[WORD_W-1] : 1'b1;

endmodule

// ===== rtl/core/psnm_dist_unit.sv =====
// Shared distance unit: squared RGB distance between the shaded colour and
// one palette candidate per cycle, registered with the candidate tag.
// Depends on psnm_pkg.
`timescale 1ns / 1ps

module psnm_dist_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [psnm_pkg::CHAN_W-1:0]  shade_red,
   input  logic [psnm_pkg::CHAN_W-1:0]  shade_green,
   input  logic [psnm_pkg::CHAN_W-1:0]  shade_blue,
   input  logic [psnm_pkg::COLOR_W-1:0] cand_color,
   input  psnm_pkg::cand_type           cand_in,
   output logic [psnm_pkg::SUM_W-1:0]   sum_sq,
   output psnm_pkg::cand_type           cand_out
);

   localparam int CW = psnm_pkg::CHAN_W;
   localparam int SW = 2 * psnm_pkg::CHAN_W;

   logic [CW-1:0]              diff_r, diff_g, diff_b;
   logic [CW-1:0]              c_r, c_g, c_b;
   logic [SW-1:0]              sq_r, sq_g, sq_b;
   logic [psnm_pkg::SUM_W-1:0] dist_in;
   logic [psnm_pkg::SUM_W-1:0] dist_ff;
   psnm_pkg::cand_type         cand_ff;

   assign c_r = cand_color[3*CW-1:2*CW];
   assign c_g = cand_color[2*CW-1:CW];
   assign c_b = cand_color[CW-1:0];

   // Absolute channel differences
   assign diff_r = (shade_red   >= c_r) ? (shade_red   - c_r) : (c_r - shade_red);
   assign diff_g = (shade_green >= c_g) ? (shade_green - c_g) : (c_g - shade_green);
   assign diff_b = (shade_blue  >= c_b) ? (shade_blue  - c_b) : (c_b - shade_blue);

   // Squares and sum
   assign sq_r    = SW'(diff_r) * SW'(diff_r);
   assign sq_g    = SW'(diff_g) * SW'(diff_g);
   assign sq_b    = SW'(diff_b) * SW'(diff_b);
   assign dist_in = psnm_pkg::SUM_W'(sq_r) + psnm_pkg::SUM_W'(sq_g)
                  + psnm_pkg::SUM_W'(sq_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else begin
         cand_ff.valid <= cand_in.valid;
      end
      cand_ff.avail <= cand_in.avail;
      cand_ff.idx   <= cand_in.idx;
      dist_ff       <= dist_in;
   end

   assign sum_sq   = dist_ff;
   assign cand_out = cand_ff;

endmodule

// ===== rtl/core/palette_shade_nearest_match.sv =====
// Palette shade nearest-match: a write transaction loads one palette entry and
// the block stays ready. A query transaction shades the queried colour one
// channel at a time through a single multiplier, then the palette is scanned
// one candidate per cycle through its single read port, the read tag and
// distance registers drain and the result is posted.
// Requests are stalled during a query; a finished result waits in an output
// register while the next transaction is taken. Reset needs no clearing pass.
// Depends on psnm_pkg, psnm_palette and psnm_dist_unit.
`timescale 1ns / 1ps

module palette_shade_nearest_match #(
   parameter int ENTRIES = psnm_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  psnm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output psnm_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psnm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psnm_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int CW    = psnm_pkg::CHAN_W;
   localparam int EW    = psnm_pkg::ENTRY_W;
   localparam int PW    = 14;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHADE = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [1:0]                      chan_ff, chan_in;
   logic [CNT_W-1:0]                scan_idx_ff, scan_idx_in;
   logic [EW-1:0]                   qentry_ff, qentry_in;
   logic [CW-1:0]                   shade_r_ff, shade_g_ff, shade_b_ff;
   logic [psnm_pkg::DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [EW-1:0]                   best_idx_ff, best_idx_in;
   psnm_pkg::cand_type              rd_cand_ff, rd_cand_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   psnm_pkg::rsp_type               rsp_data_ff;
   logic [psnm_pkg::INTENSITY_W-1:0] intensity_ff;
   logic [CW-1:0]                   target_r_ff, target_g_ff, target_b_ff;

   psnm_pkg::pal_cmd_type           pal_cmd;
   logic [psnm_pkg::COLOR_W-1:0]    pal_color;
   logic                            pal_avail;
   logic [psnm_pkg::SUM_W-1:0]      cand_dist;
   psnm_pkg::cand_type              dist_cand_in;
   psnm_pkg::cand_type              dist_cand;

   logic                            req_accept;
   logic                            req_in_range;
   logic                            issue;
   logic                            scan_done;
   logic                            rsp_load;
   logic                            better;
   logic [psnm_pkg::INTENSITY_W-1:0] k_eff;
   logic [CW-1:0]                   sh_cur, sh_tgt, sh_diff, sh_step, sh_new;
   logic [PW-1:0]                   sh_prod;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         intensity_ff <= psnm_pkg::INTENSITY_RESET;
         target_r_ff  <= '0;
         target_g_ff  <= '0;
         target_b_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            psnm_pkg::CSR_INTENSITY:    intensity_ff <= csr_data;
            psnm_pkg::CSR_TARGET_RED:   target_r_ff  <= csr_data[CW-1:0];
            psnm_pkg::CSR_TARGET_GREEN: target_g_ff  <= csr_data[CW-1:0];
            psnm_pkg::CSR_TARGET_BLUE:  target_b_ff  <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // Request side
   assign req_stall    = (state_ff != S_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = ({1'b0, req_data.entry} < (EW + 1)'(ENTRIES));

   // Palette port: writes only from idle, reads follow the sequencer
   always_comb begin
      pal_cmd.wr_en    = req_accept && req_in_range
                       && (req_data.action == psnm_pkg::ACT_WRITE);
      pal_cmd.wr_addr  = req_data.entry;
      pal_cmd.wr_avail = req_data.usable;
      pal_cmd.wr_color = {req_data.red, req_data.green, req_data.blue};
      case (state_ff)
         S_IDLE:  pal_cmd.rd_addr = req_data.entry;
         S_SCAN:  pal_cmd.rd_addr = EW'(scan_idx_ff[IDX_W-1:0]);
         default: pal_cmd.rd_addr = qentry_ff;
      endcase
   end

   psnm_palette #(
      .ENTRIES (ENTRIES)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .cmd      (pal_cmd),
      .rd_color (pal_color),
      .rd_avail (pal_avail)
   );

   // Shade one channel per cycle through the single multiplier
   assign k_eff = (intensity_ff > psnm_pkg::INTENSITY_FULL) ?
                  psnm_pkg::INTENSITY_FULL : intensity_ff;

   always_comb begin
      case (chan_ff)
         CH_RED: begin
            sh_cur = pal_color[3*CW-1:2*CW];
            sh_tgt = target_r_ff;
         end
         CH_GREEN: begin
            sh_cur = pal_color[2*CW-1:CW];
            sh_tgt = target_g_ff;
         end
         default: begin
            sh_cur = pal_color[CW-1:0];
            sh_tgt = target_b_ff;
         end
      endcase
   end

   assign sh_diff = (sh_cur <= sh_tgt) ? (sh_tgt - sh_cur) : (sh_cur - sh_tgt);
   assign sh_prod = PW'(k_eff) * PW'(sh_diff);
   assign sh_step = sh_prod[PW-1:8];
   assign sh_new  = (sh_cur <= sh_tgt) ? (sh_cur + sh_step) : (sh_cur - sh_step);

   always_ff @(posedge clock) begin
      if (state_ff == S_SHADE) begin
         case (chan_ff)
            CH_RED:   shade_r_ff <= sh_new;
            CH_GREEN: shade_g_ff <= sh_new;
            default:  shade_b_ff <= sh_new;
         endcase
      end
   end

   // Scan issue and candidate tag alongside the registered read
   assign issue = (state_ff == S_SCAN) && (scan_idx_ff < CNT_W'(ENTRIES));

   always_comb begin
      rd_cand_in.valid = issue;
      rd_cand_in.avail = 1'b0;
      rd_cand_in.idx   = EW'(scan_idx_ff[IDX_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cand_ff.valid <= 1'b0;
      end else begin
         rd_cand_ff.valid <= rd_cand_in.valid;
      end
      rd_cand_ff.avail <= rd_cand_in.avail;
      rd_cand_ff.idx   <= rd_cand_in.idx;
   end

   // Tag the read data with its availability before the distance stage
   always_comb begin
      dist_cand_in       = rd_cand_ff;
      dist_cand_in.avail = pal_avail;
   end

   psnm_dist_unit u_dist (
      .clock       (clock),
      .reset       (reset),
      .shade_red   (shade_r_ff),
      .shade_green (shade_g_ff),
      .shade_blue  (shade_b_ff),
      .cand_color  (pal_color),
      .cand_in     (dist_cand_in),
      .sum_sq      (cand_dist),
      .cand_out    (dist_cand)
   );

   // Keep the best; only a strictly smaller distance replaces it
   assign better = dist_cand.valid && dist_cand.avail
                && (cand_dist < psnm_pkg::SUM_W'(best_dist_ff));

   assign scan_done = (state_ff == S_SCAN) && !issue
                   && !rd_cand_ff.valid && !dist_cand.valid;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      scan_idx_in  = scan_idx_ff;
      qentry_in    = qentry_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_in_range
                && (req_data.action == psnm_pkg::ACT_QUERY)) begin
               qentry_in = req_data.entry;
               chan_in   = CH_RED;
               state_in  = S_SHADE;
            end
         end
         S_SHADE: begin
            if (chan_ff == CH_BLUE) begin
               scan_idx_in  = '0;
               best_dist_in = psnm_pkg::DIST_LIMIT;
               best_idx_in  = qentry_ff;
               state_in     = S_SCAN;
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
         S_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            if (better) begin
               best_dist_in = cand_dist[psnm_pkg::DIST_W-1:0];
               best_idx_in  = dist_cand.idx;
            end
            if (scan_done) begin
               if (rsp_valid_ff && rsp_stall) begin
                  state_in = S_HOLD;
               end else begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_HOLD: begin
            if (!rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      chan_ff      <= chan_in;
      scan_idx_ff  <= scan_idx_in;
      qentry_ff    <= qentry_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   // Output register: hold until taken
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff.queried_entry <= qentry_ff;
         rsp_data_ff.match_entry   <= best_idx_ff;
         rsp_data_ff.best_distance <= best_dist_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a stalled result");

   // Candidates only flow during a scan
   a_cand_in_scan: assert property (@(posedge clock) disable iff (reset)
      (rd_cand_ff.valid || dist_cand.valid) |-> (state_ff == S_SCAN))
      else $error("scan candidate outside scan");

   // A scan starts from the limit with the queried entry as match
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_SCAN) |->
         (best_dist_ff == psnm_pkg::DIST_LIMIT) && (best_idx_ff == qentry_ff))
      else $error("scan started without initial best");

   // Scan index stays at or below the palette size
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_idx_ff <= CNT_W'(ENTRIES)))
      else $error("scan index past palette end");

endmodule
